// ===== rtl/ucoc_pkg.sv =====
// ucoc_pkg: shared types and constants for the utf-8 column/offset converter
// no dependencies
`timescale 1ns / 1ps

package ucoc_pkg;

    localparam int MAX_LINE_BYTES = 65536;
    localparam int IDX_W          = $clog2(MAX_LINE_BYTES + 1);
    localparam int POS_W          = 17;
    localparam int TGT_W          = 32;

    // lead byte range boundaries
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;

    typedef enum logic [1:0] {
        CMD_BYTE_TO_U16 = 2'd0,
        CMD_U16_TO_BYTE = 2'd1,
        CMD_BYTE_TO_CP  = 2'd2,
        CMD_CP_TO_BYTE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] byte_index;
        logic [1:0]       skip_left;
        logic [IDX_W-1:0] column_count;
        logic             found;
        logic [IDX_W-1:0] found_offset;
    } line_state_t;

endpackage

// ===== rtl/ucoc_step.sv =====
// ucoc_step: per-item next-state and result logic (purely combinational)
// depends on ucoc_pkg
`timescale 1ns / 1ps

module ucoc_step
    import ucoc_pkg::*;
(
    input  line_state_t      cur,
    input  logic [1:0]       cmd,
    input  logic [TGT_W-1:0] target,
    input  logic [7:0]       data_byte,
    input  logic             no_data,
    output line_state_t      nxt,
    output logic [POS_W-1:0] result
);

    logic             take;
    logic             to_byte;
    logic             utf16;
    logic [1:0]       units;
    logic [1:0]       trail;
    logic [TGT_W-1:0] col_ext;
    logic [TGT_W-1:0] pos_ext;
    logic [IDX_W-1:0] res_full;

    assign to_byte = (cmd == CMD_U16_TO_BYTE) || (cmd == CMD_CP_TO_BYTE);
    assign utf16   = (cmd == CMD_BYTE_TO_U16) || (cmd == CMD_U16_TO_BYTE);
    assign take    = !no_data && (cur.byte_index < IDX_W'(MAX_LINE_BYTES));
    assign units   = (utf16 && data_byte >= LEAD4_MIN) ? 2'd2 : 2'd1;
    assign col_ext = TGT_W'(cur.column_count);
    assign pos_ext = TGT_W'(cur.byte_index);

    // stray continuation bytes fall in with single-byte leads
    always_comb
    begin
        if (data_byte < LEAD2_MIN)
        begin
            trail = (data_byte < CONT_MIN) ? 2'd0 : 2'd0;
        end
        else if (data_byte < LEAD3_MIN)
        begin
            trail = 2'd1;
        end
        else if (data_byte < LEAD4_MIN)
        begin
            trail = 2'd2;
        end
        else
        begin
            trail = 2'd3;
        end
    end

    always_comb
    begin
        nxt = cur;
        if (take)
        begin
            if (cur.skip_left != 2'd0)
            begin
                nxt.skip_left = cur.skip_left - 2'd1;
            end
            else
            begin
                if (to_byte)
                begin
                    if (!cur.found && col_ext >= target)
                    begin
                        nxt.found        = 1'b1;
                        nxt.found_offset = cur.byte_index;
                    end
                    else if (!cur.found)
                    begin
                        nxt.column_count = cur.column_count + IDX_W'(units);
                    end
                end
                else if (pos_ext < target)
                begin
                    nxt.column_count = cur.column_count + IDX_W'(units);
                end
                nxt.skip_left = trail;
            end
            nxt.byte_index = cur.byte_index + IDX_W'(1);
        end
    end

    always_comb
    begin
        if (!to_byte)
        begin
            res_full = nxt.column_count;
        end
        else if (nxt.found)
        begin
            res_full = nxt.found_offset;
        end
        else
        begin
            res_full = nxt.byte_index;
        end
    end

    assign result = POS_W'(res_full);

endmodule

// ===== rtl/ucoc_out_buf.sv =====
// ucoc_out_buf: result register with a skid entry behind it
// depends on ucoc_pkg
`timescale 1ns / 1ps

module ucoc_out_buf
    import ucoc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [POS_W-1:0] push_data,
    output logic             full,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [POS_W-1:0] position
);

    logic             out_valid_reg;
    logic [POS_W-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [POS_W-1:0] skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !result_stall)
        begin
            // output slot frees up this cycle
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !result_stall)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        if (push && !skid_valid_reg)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign position     = out_data_reg;

endmodule

// ===== rtl/utf8_column_offset_converter.sv =====
// utf8_column_offset_converter: top level, line state registers and result buffer
// depends on ucoc_pkg, ucoc_step, ucoc_out_buf
//
// usage:
//  - the item channel carries one byte of a utf-8 line per item (item_valid /
//    item_stall); last_byte marks the item that closes the line, no_data marks
//    an item without a byte (an empty line is a single no_data, last_byte item)
//  - cmd selects byte-to-column or column-to-byte, in utf-16 units or code
//    points; target is the offset or column being converted
//  - the result channel (result_valid / result_stall) gives one position per
//    line, on the item that carries last_byte
//  - throughput: one item per cycle while item_stall is low; the classify/count
//    step sits between the line state registers and the result register
//  - a closing item's result is registered in the output register or skid entry
//  - a stalled result sits in the output register while a skid entry takes
//    the next one; item_stall rises only when both hold a result
//  - reset clears the line state and drops any pending results
`timescale 1ns / 1ps

module utf8_column_offset_converter
    import ucoc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [1:0]       cmd,
    input  logic [TGT_W-1:0] target,
    input  logic [7:0]       data_byte,
    input  logic             no_data,
    input  logic             last_byte,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [POS_W-1:0] position
);

    line_state_t      state_reg;
    line_state_t      state_next;
    logic [POS_W-1:0] step_result;
    logic             accept;
    logic             buf_full;

    assign accept     = item_valid && !item_stall;
    assign item_stall = buf_full;

    ucoc_step u_step (
        .cur       (state_reg),
        .cmd       (cmd),
        .target    (target),
        .data_byte (data_byte),
        .no_data   (no_data),
        .nxt       (state_next),
        .result    (step_result)
    );

    // line state clears once the closing item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= last_byte ? '0 : state_next;
        end
    end

    ucoc_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept && last_byte),
        .push_data    (step_result),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .position     (position)
    );

endmodule

// ===== rtl/ucoc_checker.sv =====
// ucoc_checker: port-level checks on the converter, bound to the top level
// depends on ucoc_pkg
`timescale 1ns / 1ps

module ucoc_checker
    import ucoc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  logic             last_byte,
    input  logic             result_valid,
    input  logic             result_stall,
    input  logic [POS_W-1:0] position
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       line_done;
    logic       result_taken;

    assign line_done    = item_valid && !item_stall && last_byte;
    assign result_taken = result_valid && !result_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (line_done && !result_taken)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!line_done && result_taken)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    // results owed: closed lines minus results taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(position))
        else $error("stalled result changed or dropped");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 2'd0)
        else $error("result shown with no closed line owed");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> pending_reg == 2'd2)
        else $error("items stalled while result buffer has room");

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> position <= POS_W'(MAX_LINE_BYTES))
        else $error("position beyond line length limit");

endmodule

bind utf8_column_offset_converter ucoc_checker u_ucoc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .position     (position)
);

// ===== verif/testbench.sv =====
// testbench for utf8_column_offset_converter: streams utf-8 lines under all four commands
// and checks each line's position against a line-state predictor; depends on ucoc_pkg
`timescale 1ns / 1ps

module testbench;
    import ucoc_pkg::*;

    typedef struct {
        cmd_t             op;
        logic [TGT_W-1:0] tgt;
        logic [7:0]       octet;
        bit               empty;
        bit               closes;
        int unsigned      gap;
        bit               hold_mark;
    } line_item_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    logic [1:0]       cmd          = CMD_BYTE_TO_U16;
    logic [TGT_W-1:0] target       = '0;
    logic [7:0]       data_byte    = '0;
    logic             no_data      = 1'b0;
    logic             last_byte    = 1'b0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic [POS_W-1:0] position;

    utf8_column_offset_converter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .target       (target),
        .data_byte    (data_byte),
        .no_data      (no_data),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .position     (position)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    line_item_t       pending[$];
    logic [POS_W-1:0] expected_pos[$];

    // predicted line state
    logic [IDX_W-1:0] ln_bytes  = '0;
    logic [1:0]       ln_trail  = '0;
    logic [IDX_W-1:0] ln_cols   = '0;
    bit               ln_hit    = 1'b0;
    logic [IDX_W-1:0] ln_hit_at = '0;

    int unsigned fill_mode     = 1;
    bit          mark_next     = 1'b0;
    int unsigned items_total   = 0;
    int unsigned items_done    = 0;
    int unsigned useful_items  = 0;
    int unsigned lines_total   = 0;
    int unsigned lines_checked = 0;
    longint unsigned budget    = 0;
    longint unsigned cycle_limit = 0;
    longint unsigned cycles    = 0;
    int unsigned in_stalls     = 0;
    int unsigned holds         = 0;
    int unsigned errors        = 0;

    function automatic int unsigned draw_gap(int unsigned mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 14);
            2: return $urandom_range(0, 2);
            default: return ($urandom_range(0, 7) == 0) ? 14 : 0;
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    function automatic logic [TGT_W-1:0] pick_target(int unsigned span);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom_range(0, span + 3);
        endcase
    endfunction

    function automatic void put(cmd_t op, logic [TGT_W-1:0] tgt, logic [7:0] octet,
                                bit empty, bit closes);
        line_item_t it;
        it.op        = op;
        it.tgt       = tgt;
        it.octet     = octet;
        it.empty     = empty;
        it.closes    = closes;
        it.gap       = draw_gap(fill_mode);
        it.hold_mark = mark_next;
        mark_next    = 1'b0;
        pending.push_back(it);
        items_total++;
        if (!empty || closes)
            useful_items++;
        if (closes)
            lines_total++;
        budget += it.gap + 1 + (closes ? 15 : 0);
    endfunction

    // short lines back to back while the receiver holds off
    function automatic void put_burst();
        cmd_t op;
        logic [TGT_W-1:0] tgt;
        bit two;
        fill_mode = 0;
        mark_next = 1'b1;
        budget += 400;
        for (int i = 0; i < 30; i++)
        begin
            op  = cmd_t'($urandom_range(0, 3));
            tgt = $urandom_range(0, 3);
            two = $urandom_range(0, 1);
            if (two)
                put(op, tgt, 8'($urandom), 1'b0, 1'b0);
            put(op, tgt, 8'($urandom), 1'b0, 1'b1);
        end
    endfunction

    function automatic void put_random_line();
        logic [7:0] octets[$];
        cmd_t op;
        logic [TGT_W-1:0] tgt;
        int unsigned n_cp;
        bit marker_close;
        fill_mode = $urandom_range(0, 3);
        if ($urandom_range(0, 19) == 0)
            n_cp = 0;
        else if ($urandom_range(0, 9) == 0)
            n_cp = $urandom_range(20, 60);
        else
            n_cp = $urandom_range(1, 12);
        for (int i = 0; i < n_cp; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: octets.push_back(8'($urandom_range(0, 8'h7F)));
                3:
                begin
                    octets.push_back(8'($urandom_range(LEAD2_MIN, 8'hDF)));
                    octets.push_back(cont_byte());
                end
                4:
                begin
                    octets.push_back(8'($urandom_range(LEAD3_MIN, 8'hEF)));
                    repeat (2) octets.push_back(cont_byte());
                end
                5:
                begin
                    octets.push_back(8'($urandom_range(LEAD4_MIN, 8'hFF)));
                    repeat (3) octets.push_back(cont_byte());
                end
                6: octets.push_back(cont_byte());
                7:
                begin
                    // lead byte with a code point that may be truncated
                    octets.push_back(8'($urandom_range(LEAD2_MIN, 8'hFF)));
                    repeat ($urandom_range(0, 2)) octets.push_back(cont_byte());
                end
                default: octets.push_back(8'($urandom));
            endcase
        end
        op  = cmd_t'($urandom_range(0, 3));
        tgt = pick_target(octets.size());
        if (octets.size() == 0)
            put(op, tgt, 8'($urandom), 1'b1, 1'b1);
        else
        begin
            marker_close = ($urandom_range(0, 9) == 0);
            foreach (octets[i])
            begin
                if ($urandom_range(0, 29) == 0)
                    put(op, tgt, 8'($urandom), 1'b1, 1'b0);
                if ($urandom_range(0, 24) == 0)
                begin
                    op  = cmd_t'($urandom_range(0, 3));
                    tgt = pick_target(octets.size());
                end
                put(op, tgt, octets[i], 1'b0, !marker_close && i == octets.size() - 1);
            end
            if (marker_close)
                put(op, tgt, 8'($urandom), 1'b1, 1'b1);
        end
    endfunction

    function automatic void advance_line(line_item_t it);
        bit to_byte;
        bit utf16;
        logic [IDX_W-1:0] units;
        logic [POS_W-1:0] res;
        to_byte = (it.op == CMD_U16_TO_BYTE || it.op == CMD_CP_TO_BYTE);
        utf16   = (it.op == CMD_BYTE_TO_U16 || it.op == CMD_U16_TO_BYTE);
        if (!it.empty && ln_bytes < MAX_LINE_BYTES)
        begin
            if (ln_trail != 0)
                ln_trail = ln_trail - 2'd1;
            else
            begin
                units = (utf16 && it.octet >= LEAD4_MIN) ? 2 : 1;
                if (to_byte)
                begin
                    if (!ln_hit && ln_cols >= it.tgt)
                    begin
                        ln_hit    = 1'b1;
                        ln_hit_at = ln_bytes;
                    end
                    if (!ln_hit)
                        ln_cols = ln_cols + units;
                end
                else if (ln_bytes < it.tgt)
                    ln_cols = ln_cols + units;
                ln_trail = (it.octet >= LEAD4_MIN) ? 2'd3 :
                           (it.octet >= LEAD3_MIN) ? 2'd2 :
                           (it.octet >= LEAD2_MIN) ? 2'd1 : 2'd0;
            end
            ln_bytes = ln_bytes + 1'b1;
        end
        if (it.closes)
        begin
            res = !to_byte ? ln_cols : (ln_hit ? ln_hit_at : ln_bytes);
            expected_pos.push_back(res);
            ln_bytes  = '0;
            ln_trail  = '0;
            ln_cols   = '0;
            ln_hit    = 1'b0;
            ln_hit_at = '0;
        end
    endfunction

    // sender
    line_item_t  on_bus;
    int unsigned tx_wait;
    bit          tx_busy;
    bit          tx_mark;
    bit          popped;
    logic        hold_go = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            hold_go    <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            tx_busy = item_valid;
            tx_mark = 1'b0;
            popped  = 1'b0;
            if (item_valid && !item_stall)
            begin
                advance_line(on_bus);
                items_done++;
                tx_busy = 1'b0;
            end
            if (!tx_busy && pending.size() > 0)
            begin
                if (tx_wait < pending[0].gap)
                    tx_wait++;
                else
                begin
                    on_bus  = pending.pop_front();
                    tx_wait = 0;
                    tx_busy = 1'b1;
                    popped  = 1'b1;
                    tx_mark = on_bus.hold_mark;
                end
            end
            item_valid <= tx_busy;
            hold_go    <= tx_mark;
            if (popped)
            begin
                cmd       <= on_bus.op;
                target    <= on_bus.tgt;
                data_byte <= on_bus.octet;
                no_data   <= on_bus.empty;
                last_byte <= on_bus.closes;
            end
        end
    end

    // receiver and checker
    int unsigned      rx_wait;
    int unsigned      rx_mode = 1;
    int unsigned      hold_left;
    bit               rx_hold;
    logic [POS_W-1:0] want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_wait   = 0;
            hold_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_pos.size() == 0)
                begin
                    errors++;
                    $error("position %0d arrived with no line pending", position);
                end
                else
                begin
                    want = expected_pos.pop_front();
                    if (position !== want)
                    begin
                        errors++;
                        $error("position: expected %0d, got %0d", want, position);
                    end
                end
                lines_checked++;
                if (lines_checked % 50 == 0)
                    rx_mode = $urandom_range(0, 3);
                rx_wait = draw_gap(rx_mode);
            end
            if (hold_go)
            begin
                hold_left = 400;
                holds++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rx_hold = 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                rx_hold = 1'b1;
            end
            else
                rx_hold = 1'b0;
            result_stall <= rx_hold;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (item_valid && item_stall)
            in_stalls++;
        if (cycle_limit != 0 && cycles > cycle_limit)
        begin
            $display("timeout after %0d cycles, %0d of %0d items sent",
                     cycles, items_done, items_total);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned random_goal;
        int unsigned half_goal;
        bit second_burst;

        // empty lines and a one-byte line, extreme targets
        put(CMD_BYTE_TO_U16, '0, 8'hFF, 1'b1, 1'b1);
        put(CMD_CP_TO_BYTE,  '1, 8'h00, 1'b1, 1'b1);
        put(CMD_BYTE_TO_CP,  '0, 8'h00, 1'b0, 1'b1);
        // target splits a 4-byte code point, which still counts two units
        put(CMD_BYTE_TO_U16, 1, 8'hF0, 1'b0, 1'b0);
        put(CMD_BYTE_TO_U16, 1, 8'h9F, 1'b0, 1'b0);
        put(CMD_BYTE_TO_U16, 1, 8'h98, 1'b0, 1'b0);
        put(CMD_BYTE_TO_U16, 1, 8'h80, 1'b0, 1'b0);
        put(CMD_BYTE_TO_U16, 1, 8'h41, 1'b0, 1'b1);
        // line ends inside a code point
        put(CMD_U16_TO_BYTE, 5, 8'hC3, 1'b0, 1'b0);
        put(CMD_U16_TO_BYTE, 5, 8'hA9, 1'b0, 1'b0);
        put(CMD_U16_TO_BYTE, 5, 8'hFF, 1'b0, 1'b1);
        // stray continuation, byte-less item mid-line, byte-less close
        put(CMD_CP_TO_BYTE, 2, 8'h80, 1'b0, 1'b0);
        put(CMD_CP_TO_BYTE, 2, 8'hE2, 1'b0, 1'b0);
        put(CMD_CP_TO_BYTE, 2, 8'h55, 1'b1, 1'b0);
        put(CMD_CP_TO_BYTE, 2, 8'h82, 1'b0, 1'b0);
        put(CMD_CP_TO_BYTE, 2, 8'hAC, 1'b0, 1'b0);
        put(CMD_CP_TO_BYTE, 2, 8'h7F, 1'b0, 1'b0);
        put(CMD_CP_TO_BYTE, 2, 8'hAA, 1'b1, 1'b1);
        // command changes within the line
        put(CMD_BYTE_TO_U16, '0, 8'hBF, 1'b0, 1'b0);
        put(CMD_U16_TO_BYTE, '1, 8'hC0, 1'b0, 1'b0);
        put(CMD_BYTE_TO_CP,  '1, 8'hDF, 1'b0, 1'b1);
        // column target reached at a later code-point start
        put(CMD_U16_TO_BYTE, 1, 8'hE0, 1'b0, 1'b0);
        put(CMD_U16_TO_BYTE, 1, 8'hA0, 1'b0, 1'b0);
        put(CMD_U16_TO_BYTE, 1, 8'h80, 1'b0, 1'b0);
        put(CMD_U16_TO_BYTE, 1, 8'hEF, 1'b0, 1'b1);

        put_burst();
        random_goal  = 1650;
        half_goal    = 825;
        second_burst = 1'b0;
        while (useful_items < random_goal)
        begin
            if (!second_burst && useful_items > half_goal)
            begin
                put_burst();
                second_burst = 1'b1;
            end
            put_random_line();
        end
        cycle_limit = 4 * budget + 2000;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (items_done != items_total)
            @(posedge clk);
        while (expected_pos.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d lines over %0d items in all four conversions, with mixed stalls",
                 lines_checked, items_done);
        $display("%0d receiver hold-offs, input held back for %0d cycles", holds, in_stalls);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== utf8_column_offset_converter.f =====
rtl/ucoc_pkg.sv
rtl/ucoc_step.sv
rtl/ucoc_out_buf.sv
rtl/utf8_column_offset_converter.sv
rtl/ucoc_checker.sv
verif/testbench.sv
